### rtl/utg_pkg.sv
// Shared types, constants and helper function of the UTF-8 glyph shaper.
package utg_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int CP_W                = 21;
    localparam int OFF_OUT_W           = 16;
    localparam int GLYPH_W             = 7;
    localparam int PX_W                = 24;
    localparam int MAX_RECS            = 4;
    localparam int REC_CNT_W           = 3;
    localparam int HELD_DEPTH          = 3;

    localparam logic [PX_W-1:0] PX_RESET = 24'd4096;

    // Lead and continuation byte classes: (byte & mask) == match.
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_MATCH  = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_MATCH = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_MATCH = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_MATCH = 8'hF0;

    localparam logic [2:0] SEQ_LEN_1 = 3'd1;
    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    localparam logic [CP_W-1:0] GLYPH_FIRST_CP = 21'h20;
    localparam logic [CP_W-1:0] GLYPH_LAST_CP  = 21'h7E;

    typedef struct packed {
        logic [CP_W-1:0]      code_point;
        logic [OFF_OUT_W-1:0] cluster_offset;
    } utg_rec_t;

    typedef struct packed {
        utg_rec_t [MAX_RECS-1:0] recs;
        logic [REC_CNT_W-1:0]    count;
        logic                    fin;
    } utg_batch_t;

    // Printable ASCII maps to glyphs 1..95, everything else to the missing glyph.
    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] idx;
        idx = cp - (GLYPH_FIRST_CP - 21'd1);
        if (cp >= GLYPH_FIRST_CP && cp <= GLYPH_LAST_CP) begin
            return idx[GLYPH_W-1:0];
        end
        return '0;
    endfunction

endpackage

### rtl/utg_decode.sv
// Sequence decoder: held bytes, partial value and byte position, and the records of one byte.
module utg_decode #(
    parameter int OFFSET_BITS = utg_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         text_byte,
    input  logic               final_byte,
    output utg_pkg::utg_batch_t batch
);

    logic [7:0]                  held_reg  [utg_pkg::HELD_DEPTH];
    logic [7:0]                  held_next [utg_pkg::HELD_DEPTH];
    logic [1:0]                  hc_reg, hc_next;
    logic [2:0]                  exp_reg, exp_next;
    logic [utg_pkg::CP_W-1:0]    pv_reg, pv_next;
    logic [OFFSET_BITS-1:0]      pos_reg, pos_next;

    logic                        is_cont;
    logic                        taken;
    logic [utg_pkg::CP_W-1:0]    pv_cont;
    logic [OFFSET_BITS-1:0]      start_held;
    logic [OFFSET_BITS-1:0]      start_fin;
    logic [2:0]                  lead_len;
    logic [utg_pkg::CP_W-1:0]    lead_val;
    logic [utg_pkg::REC_CNT_W-1:0] n;
    utg_pkg::utg_rec_t [utg_pkg::MAX_RECS-1:0] recs;

    always_comb begin
        lead_len = utg_pkg::SEQ_LEN_1;
        lead_val = utg_pkg::CP_W'(text_byte);
        if ((text_byte & utg_pkg::LEAD2_MASK) == utg_pkg::LEAD2_MATCH) begin
            lead_len = utg_pkg::SEQ_LEN_2;
            lead_val = utg_pkg::CP_W'(text_byte[4:0]);
        end else if ((text_byte & utg_pkg::LEAD3_MASK) == utg_pkg::LEAD3_MATCH) begin
            lead_len = utg_pkg::SEQ_LEN_3;
            lead_val = utg_pkg::CP_W'(text_byte[3:0]);
        end else if ((text_byte & utg_pkg::LEAD4_MASK) == utg_pkg::LEAD4_MATCH) begin
            lead_len = utg_pkg::SEQ_LEN_4;
            lead_val = utg_pkg::CP_W'(text_byte[2:0]);
        end
    end

    always_comb begin
        recs       = '0;
        n          = '0;
        held_next  = held_reg;
        hc_next    = hc_reg;
        exp_next   = exp_reg;
        pv_next    = pv_reg;
        pos_next   = pos_reg;
        taken      = 1'b0;
        start_fin  = '0;
        is_cont    = (text_byte & utg_pkg::CONT_MASK) == utg_pkg::CONT_MATCH;
        pv_cont    = {pv_reg[utg_pkg::CP_W-7:0], text_byte[5:0]};
        start_held = pos_reg - OFFSET_BITS'(hc_reg);

        if (hc_reg != 2'd0) begin
            if (is_cont) begin
                taken    = 1'b1;
                pos_next = pos_reg + OFFSET_BITS'(1);
                if ({1'b0, hc_reg} + 3'd1 >= exp_reg) begin
                    recs[0].code_point     = pv_cont;
                    recs[0].cluster_offset = utg_pkg::OFF_OUT_W'(start_held);
                    n        = 3'd1;
                    hc_next  = 2'd0;
                    exp_next = utg_pkg::SEQ_LEN_1;
                    pv_next  = '0;
                end else if (hc_reg != 2'd3) begin
                    held_next[hc_reg] = text_byte;
                    hc_next           = hc_reg + 2'd1;
                    pv_next           = pv_cont;
                end
            end else begin
                // Broken sequence: every held byte goes out alone at its own offset.
                for (int k = 0; k < utg_pkg::HELD_DEPTH; k++) begin
                    if (k < int'(hc_reg)) begin
                        recs[n[1:0]].code_point     = utg_pkg::CP_W'(held_reg[k]);
                        recs[n[1:0]].cluster_offset =
                            utg_pkg::OFF_OUT_W'(start_held + OFFSET_BITS'(k));
                        n = n + 3'd1;
                    end
                end
                hc_next  = 2'd0;
                exp_next = utg_pkg::SEQ_LEN_1;
                pv_next  = '0;
            end
        end

        if (!taken) begin
            if (lead_len == utg_pkg::SEQ_LEN_1) begin
                recs[n[1:0]].code_point     = utg_pkg::CP_W'(text_byte);
                recs[n[1:0]].cluster_offset = utg_pkg::OFF_OUT_W'(pos_reg);
                n = n + 3'd1;
            end else begin
                held_next[0] = text_byte;
                hc_next      = 2'd1;
                exp_next     = lead_len;
                pv_next      = lead_val;
            end
            pos_next = pos_reg + OFFSET_BITS'(1);
        end

        if (final_byte) begin
            // End of text inside a sequence: the held bytes go out one record each.
            start_fin = pos_next - OFFSET_BITS'(hc_next);
            for (int k = 0; k < utg_pkg::HELD_DEPTH; k++) begin
                if (k < int'(hc_next)) begin
                    recs[n[1:0]].code_point     = utg_pkg::CP_W'(held_next[k]);
                    recs[n[1:0]].cluster_offset =
                        utg_pkg::OFF_OUT_W'(start_fin + OFFSET_BITS'(k));
                    n = n + 3'd1;
                end
            end
            hc_next  = 2'd0;
            exp_next = utg_pkg::SEQ_LEN_1;
            pv_next  = '0;
            pos_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hc_reg  <= 2'd0;
            exp_reg <= utg_pkg::SEQ_LEN_1;
            pv_reg  <= '0;
            pos_reg <= '0;
        end else if (accept) begin
            hc_reg  <= hc_next;
            exp_reg <= exp_next;
            pv_reg  <= pv_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

    assign batch.recs  = recs;
    assign batch.count = n;
    assign batch.fin   = final_byte;

endmodule

### rtl/utg_out_queue.sv
// Result register holding the records of one byte and handing them out one word per cycle while m_ready is high.
module utg_out_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  utg_pkg::utg_batch_t               batch,
    output logic                              free,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [utg_pkg::CP_W-1:0]          m_code_point,
    output logic [utg_pkg::GLYPH_W-1:0]       m_glyph_number,
    output logic [utg_pkg::OFF_OUT_W-1:0]     m_cluster_offset,
    output logic                              m_run_last,
    output logic                              m_text_last
);

    utg_pkg::utg_rec_t [utg_pkg::MAX_RECS-1:0] recs_reg;
    logic                                      fin_reg;
    logic [utg_pkg::REC_CNT_W-1:0]             cnt_reg;
    logic [1:0]                                idx_reg;
    logic                                      take;
    logic                                      last;
    utg_pkg::utg_rec_t                         cur;

    assign cur     = recs_reg[idx_reg];
    assign m_valid = cnt_reg != '0;
    assign take    = m_valid && m_ready;
    assign last    = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    // The next byte's records may load in the cycle the last word leaves.
    assign free    = (cnt_reg == '0) || (take && last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= batch.count;
            idx_reg <= 2'd0;
        end else if (take) begin
            if (last) begin
                cnt_reg <= '0;
                idx_reg <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            recs_reg <= batch.recs;
            fin_reg  <= batch.fin;
        end
    end

    assign m_code_point     = cur.code_point;
    assign m_glyph_number   = utg_pkg::glyph_of(cur.code_point);
    assign m_cluster_offset = cur.cluster_offset;
    assign m_run_last       = m_valid && last;
    assign m_text_last      = m_valid && last && fin_reg;

endmodule

### rtl/utf8_to_glyph_shaper_top.sv
// Top level of the UTF-8 to glyph record shaper with its pixel size register.
// The block takes one text byte per cycle while s_ready is high and returns one glyph
// record per decoded code point or per byte of a broken sequence, one record per output
// word. A byte may release several records, at most four (a broken sequence, or the
// final byte of a text that ends mid-sequence). The input is held until the output
// register has drained the records one word per cycle while m_ready is high, since the
// next byte's records load only as the last word leaves. The advance equals the pixel
// size register, which should only be written while no byte is in flight.
module utf8_to_glyph_shaper_top #(
    parameter int OFFSET_BITS = utg_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_text_byte,
    input  logic                              s_final_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [utg_pkg::CP_W-1:0]          m_code_point,
    output logic [utg_pkg::GLYPH_W-1:0]       m_glyph_number,
    output logic [utg_pkg::OFF_OUT_W-1:0]     m_cluster_offset,
    output logic [utg_pkg::PX_W-1:0]          m_advance_q9,
    output logic                              m_run_last,
    output logic                              m_text_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [utg_pkg::PX_W-1:0]          cfg_pixel_size_q8
);

    logic                      accept;
    logic                      free;
    logic [utg_pkg::PX_W-1:0]  px_reg;
    utg_pkg::utg_batch_t       batch;

    assign s_ready   = free;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg <= utg_pkg::PX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            px_reg <= cfg_pixel_size_q8;
        end
    end

    // Half a pixel size in 1/512 units is the q8 pixel size itself.
    assign m_advance_q9 = px_reg;

    utg_decode #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .text_byte (s_text_byte),
        .final_byte(s_final_byte),
        .batch     (batch)
    );

    utg_out_queue u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (accept),
        .batch           (batch),
        .free            (free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_glyph_number  (m_glyph_number),
        .m_cluster_offset(m_cluster_offset),
        .m_run_last      (m_run_last),
        .m_text_last     (m_text_last)
    );

    // With no word waiting, the input side is never stalled.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while no result is pending");

    // The last byte of a text always yields at least one record.
    a_final_yields: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_final_byte |=> m_valid && !s_ready || m_valid && m_ready)
        else $error("final byte produced no record");

    // A nonzero glyph only comes from printable ASCII.
    a_glyph_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_glyph_number != '0 |->
            m_code_point >= utg_pkg::GLYPH_FIRST_CP && m_code_point <= utg_pkg::GLYPH_LAST_CP)
        else $error("glyph index for a code point outside printable ASCII");

    // End of text is flagged only on the closing word of a byte's records.
    a_text_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_text_last |-> m_run_last && m_valid)
        else $error("text end flagged inside a run");

endmodule
